// ===== rtl/saw_pkg.sv =====
// shared types and constants for the stop-and-wait arq node
// no dependencies; imported by saw_ctrl, saw_dp and stop_and_wait_arq_node_top
`default_nettype none

package saw_pkg;

    // default sizes, used as the parameter defaults of saw_dp and the top level
    localparam int DEF_QUEUE_DEPTH = 16;
    localparam int DEF_ID_WIDTH    = 16;

    // fixed field widths
    localparam int OPCODE_W = 3;
    localparam int ACTION_W = 3;
    localparam int TIMER_W  = 16;
    localparam int TOTAL_W  = 32;

    // register port
    localparam int APB_ADDR_W = 2;
    localparam int APB_DATA_W = 32;
    localparam logic [APB_ADDR_W-1:0] ADDR_TIMEOUT  = 2'd0;
    localparam logic [TIMER_W-1:0]    TIMEOUT_RESET = 16'd1000;

    // link event codes
    typedef enum logic [OPCODE_W-1:0] {
        OP_TICK = 3'd0,
        OP_NEW  = 3'd1,
        OP_ACK  = 3'd2,
        OP_NACK = 3'd3,
        OP_DATA = 3'd4
    } opcode_t;

    // result action codes
    typedef enum logic [ACTION_W-1:0] {
        ACT_NONE    = 3'd0,
        ACT_SEND    = 3'd1,
        ACT_ACK     = 3'd2,
        ACT_NACK    = 3'd3,
        ACT_DELIVER = 3'd4
    } action_t;

    // controller states
    typedef enum logic [1:0] {
        S_IDLE = 2'd0,
        S_EXEC = 2'd1,
        S_OUT  = 2'd2
    } ctrl_state_t;

    // controller to datapath commands
    typedef struct packed {
        logic capture;
        logic execute;
        logic load_ack;
    } dp_cmd_t;

    // datapath to controller status
    typedef struct packed {
        logic second_pending;
    } dp_status_t;

endpackage

`default_nettype wire

// ===== rtl/saw_ctrl.sv =====
// sequencing state machine for the stop-and-wait arq node
// depends on saw_pkg; drives the handshakes and the saw_dp command struct
`default_nettype none

module saw_ctrl
    import saw_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       in_valid,
    output logic            in_ready,
    output logic            out_valid,
    input  wire logic       out_ready,
    input  wire dp_status_t status,
    output dp_cmd_t         cmd
);

    ctrl_state_t state_reg;
    ctrl_state_t state_next;

    // state register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // next state and commands
    always_comb
    begin
        state_next   = state_reg;
        in_ready     = 1'b0;
        out_valid    = 1'b0;
        cmd.capture  = 1'b0;
        cmd.execute  = 1'b0;
        cmd.load_ack = 1'b0;
        unique case (state_reg)
            S_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.capture = 1'b1;
                    state_next  = S_EXEC;
                end
            end
            S_EXEC:
            begin
                cmd.execute = 1'b1;
                state_next  = S_OUT;
            end
            S_OUT:
            begin
                out_valid = 1'b1;
                if (out_ready)
                begin
                    // a clean data frame still owes its ack transaction
                    if (status.second_pending)
                    begin
                        cmd.load_ack = 1'b1;
                    end
                    else
                    begin
                        state_next = S_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

endmodule

`default_nettype wire

// ===== rtl/saw_dp.sv =====
// datapath of the stop-and-wait arq node: pending fifo, timer, counters, result regs
// depends on saw_pkg; commanded by saw_ctrl
`default_nettype none

module saw_dp
    import saw_pkg::*;
#(
    parameter int QUEUE_DEPTH = DEF_QUEUE_DEPTH,
    parameter int ID_WIDTH    = DEF_ID_WIDTH
) (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire dp_cmd_t                           cmd,
    output dp_status_t                             status,
    input  wire logic [TIMER_W-1:0]                timeout_ticks,
    input  wire logic [OPCODE_W-1:0]               opcode,
    input  wire logic [ID_WIDTH-1:0]               packet_id,
    input  wire logic                              bit_error,
    output logic [ACTION_W-1:0]                    action,
    output logic [ID_WIDTH-1:0]                    out_packet_id,
    output logic [$clog2(QUEUE_DEPTH+1)-1:0]       queue_length,
    output logic [TOTAL_W-1:0]                     sent_count,
    output logic [TOTAL_W-1:0]                     received_count,
    output logic                                   overflow,
    output logic                                   last
);

    localparam int PTR_W = $clog2(QUEUE_DEPTH);
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
    localparam logic [CNT_W-1:0] DEPTH_C  = CNT_W'(QUEUE_DEPTH);
    localparam logic [CNT_W:0]   DEPTH_W  = (CNT_W + 1)'(QUEUE_DEPTH);
    localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(QUEUE_DEPTH - 1);

    // captured transaction
    logic [OPCODE_W-1:0] op_reg;
    logic [ID_WIDTH-1:0] pid_reg;
    logic                err_reg;

    // pending fifo storage and registered head read
    logic [ID_WIDTH-1:0] fifo_mem [QUEUE_DEPTH];
    logic [ID_WIDTH-1:0] rd_data_reg;

    // protocol state
    logic [PTR_W-1:0]    head_reg, head_next;
    logic [CNT_W-1:0]    count_reg, count_next;
    logic                busy_reg, busy_next;
    logic [ID_WIDTH-1:0] outst_reg, outst_next;
    logic [TIMER_W-1:0]  timer_reg, timer_next;
    logic [TOTAL_W-1:0]  acked_reg, accepted_reg;

    // result registers
    action_t             act_reg;
    logic [ID_WIDTH-1:0] id_reg;
    logic                ovf_reg;
    logic                last_reg;

    // step decode
    logic                push, pop, ovf, ack_inc, two;
    action_t             act;
    logic [ID_WIDTH-1:0] id_res;
    logic [CNT_W:0]      tail_sum;
    logic [CNT_W:0]      tail_wrap;
    logic [PTR_W-1:0]    tail;

    // write slot: head plus count, folded once
    assign tail_sum  = (CNT_W + 1)'(head_reg) + (CNT_W + 1)'(count_reg);
    assign tail_wrap = (tail_sum >= DEPTH_W) ? (tail_sum - DEPTH_W) : tail_sum;
    assign tail      = tail_wrap[PTR_W-1:0];

    // one protocol step, evaluated in the execute cycle
    always_comb
    begin
        push       = 1'b0;
        pop        = 1'b0;
        ovf        = 1'b0;
        ack_inc    = 1'b0;
        two        = 1'b0;
        act        = ACT_NONE;
        id_res     = '0;
        busy_next  = busy_reg;
        timer_next = timer_reg;
        outst_next = outst_reg;
        unique case (op_reg)
            OP_TICK:
            begin
                if (busy_reg)
                begin
                    if (timer_reg <= TIMER_W'(1))
                    begin
                        timer_next = timeout_ticks;
                        act        = ACT_SEND;
                        id_res     = outst_reg;
                    end
                    else
                    begin
                        timer_next = timer_reg - TIMER_W'(1);
                    end
                end
            end
            OP_NEW:
            begin
                if (count_reg == DEPTH_C)
                begin
                    ovf = 1'b1;
                end
                else
                begin
                    push = 1'b1;
                    if (!busy_reg)
                    begin
                        // empty fifo: the new packet goes straight out
                        pop    = 1'b1;
                        act    = ACT_SEND;
                        id_res = (count_reg == '0) ? pid_reg : rd_data_reg;
                    end
                end
            end
            OP_ACK:
            begin
                if (!err_reg && busy_reg)
                begin
                    ack_inc   = 1'b1;
                    busy_next = 1'b0;
                    if (count_reg != '0)
                    begin
                        pop    = 1'b1;
                        act    = ACT_SEND;
                        id_res = rd_data_reg;
                    end
                end
            end
            OP_NACK:
            begin
                if (!err_reg && busy_reg)
                begin
                    timer_next = timeout_ticks;
                    act        = ACT_SEND;
                    id_res     = outst_reg;
                end
            end
            OP_DATA:
            begin
                if (err_reg)
                begin
                    act = ACT_NACK;
                end
                else
                begin
                    act    = ACT_DELIVER;
                    id_res = pid_reg;
                    two    = 1'b1;
                end
            end
            default:
            begin
            end
        endcase
        // start of a new outstanding packet
        if (pop)
        begin
            busy_next  = 1'b1;
            timer_next = timeout_ticks;
            outst_next = id_res;
        end
    end

    assign count_next = count_reg + CNT_W'(push) - CNT_W'(pop);
    assign head_next  = !pop ? head_reg :
                        ((head_reg == LAST_PTR) ? '0 : head_reg + PTR_W'(1));

    // capture of the accepted transaction
    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            op_reg  <= opcode;
            pid_reg <= packet_id;
            err_reg <= bit_error;
        end
    end

    // fifo memory: write at tail, registered read of head
    always_ff @(posedge clk)
    begin
        if (cmd.execute && push)
        begin
            fifo_mem[tail] <= pid_reg;
        end
        if (cmd.capture)
        begin
            rd_data_reg <= fifo_mem[head_reg];
        end
    end

    // protocol state update
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg     <= '0;
            count_reg    <= '0;
            busy_reg     <= 1'b0;
            outst_reg    <= '0;
            timer_reg    <= '0;
            acked_reg    <= '0;
            accepted_reg <= '0;
        end
        else if (cmd.execute)
        begin
            head_reg     <= head_next;
            count_reg    <= count_next;
            busy_reg     <= busy_next;
            outst_reg    <= outst_next;
            timer_reg    <= timer_next;
            acked_reg    <= acked_reg + TOTAL_W'(ack_inc);
            accepted_reg <= accepted_reg + TOTAL_W'(push);
        end
    end

    // result registers
    always_ff @(posedge clk)
    begin
        if (cmd.execute)
        begin
            act_reg  <= act;
            id_reg   <= id_res;
            ovf_reg  <= ovf;
            last_reg <= !two;
        end
        else if (cmd.load_ack)
        begin
            act_reg  <= ACT_ACK;
            id_reg   <= '0;
            ovf_reg  <= 1'b0;
            last_reg <= 1'b1;
        end
    end

    assign status.second_pending = !last_reg;

    assign action         = act_reg;
    assign out_packet_id  = id_reg;
    assign queue_length   = count_reg;
    assign sent_count     = acked_reg;
    assign received_count = accepted_reg;
    assign overflow       = ovf_reg;
    assign last           = last_reg;

    // an idle node never holds queued packets
    a_idle_empty: assert property (@(posedge clk) disable iff (!rst_n)
        !busy_reg |-> (count_reg == '0))
        else $error("packets queued while node idle");

    // fill level and head pointer stay within the fifo
    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        (count_reg <= DEPTH_C) && (head_reg <= LAST_PTR))
        else $error("fifo pointer or count out of range");

    // a dropped packet leaves the fill level and accepted total unchanged
    a_drop_holds: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.execute && ovf) |=> ($stable(count_reg) && $stable(accepted_reg)))
        else $error("dropped packet changed fifo state");

    // the second transaction of a data frame is a final ack without a handle
    a_second_ack: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.load_ack |=> ((act_reg == ACT_ACK) && last_reg && (id_reg == '0)))
        else $error("ack after delivery malformed");

endmodule

`default_nettype wire

// ===== rtl/stop_and_wait_arq_node_top.sv =====
// top level of the stop-and-wait arq node: apb timeout register, saw_ctrl, saw_dp
// depends on saw_pkg, saw_ctrl and saw_dp
//
// usage:
//   input channel (in_valid/in_ready) carries one link event per transaction:
//   opcode, packet_id, bit_error. output channel (out_valid/out_ready) carries
//   the resulting actions; a clean data frame yields two transactions, deliver
//   then ack, and last marks the final one of each input event.
//   timeout_ticks sits at byte address 0 of the apb port; the user must write it
//   only while the node has no event in progress, which the block does not enforce.
// sequencing:
//   an event is captured in the idle state, executed in the execute state that
//   follows, and its first result is offered in the output state after that;
//   the controller handles one event at a time and the fifo head is read through
//   a registered memory port.
// reset:
//   rst_n clears the fifo pointers, busy flag, timer and totals, and sets
//   timeout_ticks to 1000; fifo contents are left as they are.
// stall:
//   while out_ready is low the result is held and in_ready stays low.
`default_nettype none

module stop_and_wait_arq_node_top
    import saw_pkg::*;
#(
    parameter int QUEUE_DEPTH = DEF_QUEUE_DEPTH,
    parameter int ID_WIDTH    = DEF_ID_WIDTH
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    // apb register port
    input  wire logic                          psel,
    input  wire logic                          penable,
    input  wire logic                          pwrite,
    input  wire logic [APB_ADDR_W-1:0]         paddr,
    input  wire logic [APB_DATA_W-1:0]         pwdata,
    output logic [APB_DATA_W-1:0]              prdata,
    output logic                               pready,
    // link event input
    input  wire logic                          in_valid,
    output logic                               in_ready,
    input  wire logic [OPCODE_W-1:0]           opcode,
    input  wire logic [ID_WIDTH-1:0]           packet_id,
    input  wire logic                          bit_error,
    // action output
    output logic                               out_valid,
    input  wire logic                          out_ready,
    output logic [ACTION_W-1:0]                action,
    output logic [ID_WIDTH-1:0]                out_packet_id,
    output logic [$clog2(QUEUE_DEPTH+1)-1:0]   queue_length,
    output logic [TOTAL_W-1:0]                 sent_count,
    output logic [TOTAL_W-1:0]                 received_count,
    output logic                               overflow,
    output logic                               last
);

    logic [TIMER_W-1:0] timeout_reg;
    dp_cmd_t            cmd;
    dp_status_t         status;

    // timeout register write
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            timeout_reg <= TIMEOUT_RESET;
        end
        else if (psel && penable && pwrite && pready && (paddr == ADDR_TIMEOUT))
        begin
            timeout_reg <= pwdata[TIMER_W-1:0];
        end
    end

    // register readback, zero-wait
    assign prdata = (paddr == ADDR_TIMEOUT) ? APB_DATA_W'(timeout_reg) : '0;
    assign pready = 1'b1;

    // controller
    saw_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .status    (status),
        .cmd       (cmd)
    );

    // datapath
    saw_dp #(
        .QUEUE_DEPTH (QUEUE_DEPTH),
        .ID_WIDTH    (ID_WIDTH)
    ) u_dp (
        .clk            (clk),
        .rst_n          (rst_n),
        .cmd            (cmd),
        .status         (status),
        .timeout_ticks  (timeout_reg),
        .opcode         (opcode),
        .packet_id      (packet_id),
        .bit_error      (bit_error),
        .action         (action),
        .out_packet_id  (out_packet_id),
        .queue_length   (queue_length),
        .sent_count     (sent_count),
        .received_count (received_count),
        .overflow       (overflow),
        .last           (last)
    );

endmodule

`default_nettype wire
